// ===== design/chs_pkg.sv =====
package chs_pkg;

	// Geometry of the table and the smoothing window.
	localparam int POINTS = 32;
	localparam int WINDOW = 7;
	localparam int FRACTION_BITS = 12;
	localparam int SAMPLE_W = 20;
	localparam int IDX_W = 6;
	localparam int QUAD_W = 4;
	localparam int DEPTH = POINTS + 1;
	localparam int MEM_AW = $clog2(DEPTH);
	localparam int HALF = WINDOW / 2;
	localparam bit WIN_ODD = (WINDOW % 2) == 1;
	localparam int TAP_AW = IDX_W + 2;

	// Angle constants, rounded to nearest from pi scaled by 2^48.
	localparam longint unsigned PI_Q48 = 64'h3243F6A8885A3;
	localparam int PI_SH = 48 - FRACTION_BITS;
	localparam longint unsigned TWO_PI = (PI_Q48 + (64'd1 << (PI_SH - 2))) >> (PI_SH - 1);
	localparam longint unsigned PI_VAL = (PI_Q48 + (64'd1 << (PI_SH - 1))) >> PI_SH;
	localparam longint unsigned HALF_PI = (PI_Q48 + (64'd1 << PI_SH)) >> (PI_SH + 1);

	// Window sum and its division by WINDOW through a reciprocal.
	localparam int SUM_W = SAMPLE_W + 2 + $clog2(WINDOW);
	localparam int MAG_W = SUM_W - 1;
	localparam int DIV_K = MAG_W + $clog2(WINDOW);
	localparam int DIV_MW = MAG_W + 1;
	localparam int DPROD_W = MAG_W + DIV_MW;
	localparam longint unsigned DIV_M_L = ((64'd1 << DIV_K) + WINDOW - 1) / WINDOW;
	localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'(DIV_M_L);
	localparam logic signed [SUM_W-1:0] TWO_PI_S = SUM_W'(TWO_PI);
	localparam logic signed [SUM_W-1:0] INIT_SUM = SUM_W'(-(longint'(HALF) * longint'(TWO_PI)));
	localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'((longint'(1) << (SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAMPLE_MIN = SUM_W'(-(longint'(1) << (SAMPLE_W - 1)));

	// Wrapping a smoothed value into one turn: offset to a positive value,
	// then remove whole turns through a reciprocal.
	localparam int X_W = SAMPLE_W + 2;
	localparam longint unsigned QWRAP = ((64'd1 << SAMPLE_W) / TWO_PI) + 1;
	localparam logic [X_W-1:0] QOFF = X_W'(PI_VAL + QWRAP * TWO_PI);
	localparam int QK = X_W + $clog2(TWO_PI);
	localparam int QMW = X_W + 1;
	localparam int QPROD_W = X_W + QMW;
	localparam longint unsigned QM_L = ((64'd1 << QK) + TWO_PI - 1) / TWO_PI;
	localparam logic [QMW-1:0] QM = QMW'(QM_L);
	localparam logic [X_W-1:0] TWO_PI_X = X_W'(TWO_PI);
	localparam logic [X_W-1:0] TH_LO = X_W'(PI_VAL - HALF_PI);
	localparam logic [X_W-1:0] TH_MID = X_W'(PI_VAL);
	localparam logic [X_W-1:0] TH_HI = X_W'(PI_VAL + HALF_PI);

	// Quadrant codes.
	localparam logic [QUAD_W-1:0] QUAD_LOW = 4'h8;
	localparam logic [QUAD_W-1:0] QUAD_NEG = 4'h4;
	localparam logic [QUAD_W-1:0] QUAD_POS = 4'h2;
	localparam logic [QUAD_W-1:0] QUAD_HIGH = 4'h1;
	localparam logic [QUAD_W-1:0] QUAD_ALL = 4'hF;

	// One classified sample on its way from the front to the back.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [IDX_W-1:0] idx;
		logic first;
		logic lo;
		logic hi;
		logic last;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smoothed_heading;
		logic [IDX_W-1:0] point_index;
		logic last_of_run;
		logic rising_ok;
		logic [QUAD_W-1:0] quadrant_mask;
		logic calibration_valid;
	} res_t;

	typedef enum logic [3:0] {
		B_LOAD,
		B_APPEND,
		B_RD,
		B_SUM,
		B_MUL,
		B_DIV,
		B_QM,
		B_QR,
		B_UPD,
		B_OUT
	} back_state_t;

	function automatic logic signed [SUM_W-1:0] sext_sum(input logic [SAMPLE_W-1:0] v);
		return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAMPLE_MAX) begin
			r = SAMPLE_MAX[SAMPLE_W-1:0];
		end else if (v < SAMPLE_MIN) begin
			r = SAMPLE_MIN[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/chs_front.sv =====
module chs_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [chs_pkg::SAMPLE_W-1:0] heading_sample,
	output logic item_valid,
	input logic item_ready,
	output chs_pkg::item_t item
);
	import chs_pkg::*;

	logic [IDX_W-1:0] cnt_q;
	item_t buf_q [2];
	logic rd_ptr_q;
	logic wr_ptr_q;
	logic [1:0] count_q;
	logic push_acc;
	logic pop_acc;
	item_t cls;

	assign full = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item = buf_q[rd_ptr_q];
	assign push_acc = push && !full;
	assign pop_acc = item_valid && item_ready;

	// Classify the incoming beat by its place in the table.
	always_comb begin
		cls.sample = heading_sample;
		cls.idx = cnt_q;
		cls.first = (cnt_q == '0);
		cls.lo = (cnt_q <= IDX_W'(HALF));
		cls.hi = (cnt_q >= IDX_W'(POINTS - HALF));
		cls.last = (cnt_q == IDX_W'(POINTS - 1));
	end

	// Sample counter and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push_acc) begin
				cnt_q <= cls.last ? '0 : cnt_q + 1'b1;
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_acc) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push_acc} - {1'b0, pop_acc};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push_acc) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// ===== design/chs_back.sv =====
module chs_back (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input chs_pkg::item_t item,
	output logic res_valid,
	input logic res_ready,
	output chs_pkg::res_t res
);
	import chs_pkg::*;

	logic signed [SAMPLE_W-1:0] mem [DEPTH];

	back_state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SAMPLE_W-1:0] s0_q;
	logic signed [SAMPLE_W-1:0] rd_out_q;
	logic signed [SAMPLE_W-1:0] rd_in_q;
	logic signed [SAMPLE_W-1:0] sm_q;
	logic signed [SAMPLE_W-1:0] prev_sm_q;
	logic wrap_out_q;
	logic wrap_in_q;
	logic neg_q;
	logic [DPROD_W-1:0] dprod_q;
	logic [X_W-1:0] x_q;
	logic [X_W-1:0] r_q;
	logic [QPROD_W-1:0] qprod_q;
	logic [QUAD_W-1:0] prev_quad_q;
	logic [QUAD_W-1:0] seen_q;
	logic rising_q;
	res_t res_q;

	logic signed [TAP_AW-1:0] p_out;
	logic signed [TAP_AW-1:0] p_in;
	logic [MEM_AW-1:0] a_out;
	logic [MEM_AW-1:0] a_in;
	logic wrap_out;
	logic wrap_in;
	logic signed [SUM_W-1:0] load_add;
	logic signed [SUM_W-1:0] walk_sum;
	logic signed [SUM_W-1:0] mag;
	logic [DPROD_W-1:0] dprod_d;
	logic [DPROD_W-1:0] qfull;
	logic [MAG_W-1:0] qmag;
	logic signed [SUM_W-1:0] qsigned;
	logic signed [SAMPLE_W-1:0] sm_div;
	logic [X_W-1:0] x_d;
	logic [QPROD_W-1:0] qprod_d;
	logic [QPROD_W-1:0] turns_full;
	logic [X_W-1:0] turns;
	logic [X_W-1:0] r_d;
	logic [QUAD_W-1:0] quad;
	logic rising_n;
	logic [QUAD_W-1:0] seen_n;
	logic last_pt;
	res_t res_d;

	function automatic logic [QUAD_W-1:0] quad_of(input logic [X_W-1:0] r);
		logic [QUAD_W-1:0] q;
		if (r < TH_LO) begin
			q = QUAD_LOW;
		end else if (r < TH_MID) begin
			q = QUAD_NEG;
		end else if (r < TH_HI) begin
			q = QUAD_POS;
		end else begin
			q = QUAD_HIGH;
		end
		return q;
	endfunction

	assign res = res_q;

	// Addresses of the tap leaving and the tap entering the window.
	always_comb begin
		p_out = $signed({2'b00, idx_q}) - TAP_AW'(HALF + 1);
		p_in = $signed({2'b00, idx_q}) + TAP_AW'(HALF);
		if (WIN_ODD) begin
			wrap_out = (p_out < 0);
			wrap_in = (p_in > TAP_AW'(POINTS));
			a_out = wrap_out ? MEM_AW'(p_out + TAP_AW'(POINTS)) : MEM_AW'(p_out);
			a_in = wrap_in ? MEM_AW'(p_in - TAP_AW'(POINTS)) : MEM_AW'(p_in);
		end else begin
			wrap_out = 1'b0;
			wrap_in = 1'b0;
			a_out = idx_q[MEM_AW-1:0];
			a_in = idx_q[MEM_AW-1:0];
		end
	end

	// Window sum arithmetic. A wrapped tap leaving the window was taken
	// with -2*pi, so removing it adds 2*pi back.
	always_comb begin
		load_add = (item.lo ? sext_sum(item.sample) : '0)
			+ (item.hi ? sext_sum(item.sample) : '0);
		walk_sum = sum_q - sext_sum(rd_out_q) + sext_sum(rd_in_q)
			+ (wrap_out_q ? TWO_PI_S : '0) + (wrap_in_q ? TWO_PI_S : '0);
		mag = sum_q[SUM_W-1] ? -sum_q : sum_q;
		dprod_d = DPROD_W'(mag[MAG_W-1:0]) * DPROD_W'(DIV_M);
		qfull = dprod_q >> DIV_K;
		qmag = qfull[MAG_W-1:0];
		qsigned = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		sm_div = sat_sample(qsigned);
	end

	// Wrap into one turn and pick the quadrant.
	always_comb begin
		x_d = {{(X_W - SAMPLE_W){sm_q[SAMPLE_W-1]}}, sm_q} + QOFF;
		qprod_d = QPROD_W'(x_d) * QPROD_W'(QM);
		turns_full = qprod_q >> QK;
		turns = turns_full[X_W-1:0];
		r_d = x_q - X_W'(turns * TWO_PI_X);
		quad = quad_of(r_q);
	end

	// Rising check and quadrant gathering up to the first fall.
	always_comb begin
		rising_n = rising_q;
		seen_n = seen_q;
		if (idx_q != '0 && rising_q) begin
			if (prev_sm_q > sm_q) begin
				rising_n = 1'b0;
			end else begin
				seen_n = seen_q | prev_quad_q;
			end
		end
		last_pt = (idx_q == IDX_W'(POINTS));
		res_d.smoothed_heading = sm_q;
		res_d.point_index = idx_q;
		res_d.last_of_run = last_pt;
		res_d.rising_ok = last_pt && rising_n;
		res_d.quadrant_mask = last_pt ? seen_n : '0;
		res_d.calibration_valid = last_pt && rising_n && (seen_n == QUAD_ALL);
	end

	// Sequencer: load, append the closing point, then walk the points.
	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			B_LOAD: begin
				item_ready = 1'b1;
				if (item_valid && item.last) begin
					state_d = B_APPEND;
				end
			end
			B_APPEND: state_d = WIN_ODD ? B_MUL : B_RD;
			B_RD: state_d = B_SUM;
			B_SUM: state_d = WIN_ODD ? B_MUL : B_QM;
			B_MUL: state_d = B_DIV;
			B_DIV: state_d = B_QM;
			B_QM: state_d = B_QR;
			B_QR: state_d = B_UPD;
			B_UPD: state_d = B_OUT;
			B_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = res_q.last_of_run ? B_LOAD : B_RD;
				end
			end
			default: state_d = B_LOAD;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
			idx_q <= '0;
			sum_q <= INIT_SUM;
			seen_q <= '0;
			rising_q <= 1'b1;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_LOAD: begin
					if (item_valid) begin
						sum_q <= sum_q + load_add;
					end
				end
				B_APPEND: begin
					idx_q <= '0;
					seen_q <= '0;
					rising_q <= 1'b1;
				end
				B_SUM: begin
					if (WIN_ODD) begin
						sum_q <= walk_sum;
					end
				end
				B_UPD: begin
					seen_q <= seen_n;
					rising_q <= rising_n;
				end
				B_OUT: begin
					if (res_ready) begin
						if (res_q.last_of_run) begin
							sum_q <= INIT_SUM;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Sample memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (state_q == B_LOAD && item_valid) begin
			mem[item.idx[MEM_AW-1:0]] <= item.sample;
		end else if (state_q == B_APPEND) begin
			mem[MEM_AW'(POINTS)] <= sat_sample(sext_sum(s0_q) + TWO_PI_S);
		end
		if (state_q == B_RD) begin
			rd_out_q <= mem[a_out];
			rd_in_q <= mem[a_in];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			B_LOAD: begin
				if (item_valid && item.first) begin
					s0_q <= item.sample;
				end
			end
			B_RD: begin
				wrap_out_q <= wrap_out;
				wrap_in_q <= wrap_in;
			end
			B_SUM: sm_q <= rd_in_q;
			B_MUL: begin
				neg_q <= sum_q[SUM_W-1];
				dprod_q <= dprod_d;
			end
			B_DIV: sm_q <= sm_div;
			B_QM: begin
				x_q <= x_d;
				qprod_q <= qprod_d;
			end
			B_QR: r_q <= r_d;
			B_UPD: begin
				res_q <= res_d;
				prev_sm_q <= sm_q;
				prev_quad_q <= quad;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/chs_outq.sv =====
module chs_outq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input chs_pkg::res_t in_res,
	output logic empty,
	input logic pop,
	output chs_pkg::res_t head
);
	import chs_pkg::*;

	res_t buf_q [2];
	logic rd_ptr_q;
	logic wr_ptr_q;
	logic [1:0] count_q;
	logic wr_acc;
	logic rd_acc;

	assign in_ready = (count_q != 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = buf_q[rd_ptr_q];
	assign wr_acc = in_valid && in_ready;
	assign rd_acc = pop && !empty;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr_acc) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_acc) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_acc} - {1'b0, rd_acc};
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (wr_acc) begin
			buf_q[wr_ptr_q] <= in_res;
		end
	end

endmodule

// ===== design/circular_heading_smoother_check.sv =====
// Circular heading smoother with calibration check. Push POINTS heading
// samples (signed Q7.12 radians) in table order; they are taken at one beat
// per cycle while full is low into a two-entry buffer and written to the
// sample memory. After the last sample the sequencer walks the POINTS+1
// points (the table plus the first sample advanced by one turn) through a
// running centered window sum, a reciprocal divider and a turn-wrapping
// quadrant unit, one point at a time through that single shared path:
// each point after point 0 reads its leaving and entering taps and, for an
// odd window, updates the sum; every point is then wrapped into one turn
// and classified. Samples of the next run may be pushed meanwhile; full
// rises once the buffer holds two of them. Results leave through a two-entry
// queue in point order; the last beat of a run carries the rising flag, the
// quadrant mask and the calibration verdict, zero on all other beats.
module circular_heading_smoother_check (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [chs_pkg::SAMPLE_W-1:0] heading_sample,
	output logic empty,
	input logic pop,
	output logic signed [chs_pkg::SAMPLE_W-1:0] smoothed_heading,
	output logic [chs_pkg::IDX_W-1:0] point_index,
	output logic last_of_run,
	output logic rising_ok,
	output logic [chs_pkg::QUAD_W-1:0] quadrant_mask,
	output logic calibration_valid
);
	import chs_pkg::*;

	logic item_valid;
	logic item_ready;
	item_t item;
	logic res_valid;
	logic res_ready;
	res_t res;
	res_t head;

	// Front: accepts and classifies sample beats.
	chs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.heading_sample(heading_sample),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item)
	);

	// Back: stores samples and computes the smoothed points.
	chs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Result queue.
	chs_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(res_valid),
		.in_ready(res_ready),
		.in_res(res),
		.empty(empty),
		.pop(pop),
		.head(head)
	);

	assign smoothed_heading = head.smoothed_heading;
	assign point_index = head.point_index;
	assign last_of_run = head.last_of_run;
	assign rising_ok = head.rising_ok;
	assign quadrant_mask = head.quadrant_mask;
	assign calibration_valid = head.calibration_valid;

endmodule

// ===== design/chs_check.sv =====
module chs_check (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic signed [chs_pkg::SAMPLE_W-1:0] smoothed_heading,
	input logic [chs_pkg::IDX_W-1:0] point_index,
	input logic last_of_run,
	input logic rising_ok,
	input logic [chs_pkg::QUAD_W-1:0] quadrant_mask,
	input logic calibration_valid
);
	import chs_pkg::*;

	// The closing beat always carries the highest point index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_run) |-> (point_index == IDX_W'(POINTS)))
		else $error("last beat of a run has the wrong point index");

	// Point indexes never go past the appended point.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (point_index <= IDX_W'(POINTS)))
		else $error("point index out of range");

	// Check fields stay clear on all but the last beat.
	a_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_of_run) |->
		(!rising_ok && quadrant_mask == '0 && !calibration_valid))
		else $error("check fields set on a beat that is not the last");

	// The verdict agrees with the rising flag and the quadrant mask.
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_run) |->
		(calibration_valid == (rising_ok && quadrant_mask == QUAD_ALL)))
		else $error("calibration verdict inconsistent");

	// A waiting result beat holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(smoothed_heading)
		&& $stable(point_index)))
		else $error("waiting result beat changed");

endmodule

bind circular_heading_smoother_check chs_check u_chs_check (.*);
